### design/terminal_key_sequence_decoder_assert.svh
// ---------------------------------------------------------------------------
// Terminal key sequence decoder assertion macros
// Shorthand for clocked implications used by the port checker.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define TKSD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset
`define TKSD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tksd_pkg.sv
// ---------------------------------------------------------------------------
// Terminal key sequence decoder package
// Shared types, codes and key table lookups.
// ---------------------------------------------------------------------------
`default_nettype none

package tksd_pkg;

	localparam int TIMER_BITS_DEF = 18;
	localparam int TIMEOUT_W      = 18;
	localparam int CFG_IDX_W      = 1;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 18'd250000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEL_BSP  = 1'd1;

	// Byte codes
	localparam logic [7:0] ESC_BYTE  = 8'h1b;
	localparam logic [7:0] DEL_BYTE  = 8'h7f;
	localparam logic [7:0] CTRL_MASK = 8'h60;
	localparam logic [7:0] CTRL_SET  = 8'h40;
	localparam logic [7:0] CH_CSI    = 8'h5b;
	localparam logic [7:0] CH_SS3    = 8'h4f;

	// Event kinds
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_SPECIAL = 2'd1;
	localparam logic [1:0] KIND_CTRL    = 2'd2;
	localparam logic [1:0] KIND_UTF     = 2'd3;

	// Special key codes
	localparam logic [3:0] K_NONE  = 4'd0;
	localparam logic [3:0] K_UP    = 4'd1;
	localparam logic [3:0] K_DOWN  = 4'd2;
	localparam logic [3:0] K_RIGHT = 4'd3;
	localparam logic [3:0] K_LEFT  = 4'd4;
	localparam logic [3:0] K_HOME  = 4'd5;
	localparam logic [3:0] K_END   = 4'd6;
	localparam logic [3:0] K_PGUP  = 4'd7;
	localparam logic [3:0] K_PGDN  = 4'd8;
	localparam logic [3:0] K_INS   = 4'd9;
	localparam logic [3:0] K_BSP   = 4'd10;
	localparam logic [3:0] K_DEL   = 4'd11;
	localparam logic [3:0] K_ESC   = 4'd12;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [3:0]  special_key;
		logic [7:0]  ctrl_letter;
		logic [31:0] char_bytes;
		logic [2:0]  char_length;
	} result_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_final(input logic [7:0] b);
		return (b == "A") || (b == "B") || (b == "C") || (b == "D") || (b == "H") ||
			(b == "F") || (b == "P") || (b == "V") || (b == "U") || (b == "Y");
	endfunction

	// Final-letter lookup; the last four letters exist only after '['
	function automatic logic [3:0] letter_key(input logic [7:0] intro, input logic [7:0] b);
		logic [3:0] k;
		k = K_NONE;
		case (b)
			"A": k = K_UP;
			"B": k = K_DOWN;
			"C": k = K_RIGHT;
			"D": k = K_LEFT;
			"H": k = K_HOME;
			"F": k = K_END;
			"P": k = (intro == CH_CSI) ? K_DEL  : K_NONE;
			"V": k = (intro == CH_CSI) ? K_PGUP : K_NONE;
			"U": k = (intro == CH_CSI) ? K_PGDN : K_NONE;
			"Y": k = (intro == CH_CSI) ? K_END  : K_NONE;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	// Digit sequence lookup: ESC [ digit ~ and ESC [ 4 h
	function automatic logic [3:0] digit_key(input logic [7:0] intro, input logic [7:0] d,
			input logic [7:0] b);
		logic [3:0] k;
		k = K_NONE;
		if (intro != CH_CSI) begin
			k = K_NONE;
		end else if (b == "h") begin
			k = (d == "4") ? K_INS : K_NONE;
		end else if (b == "~") begin
			case (d)
				"1": k = K_HOME;
				"3": k = K_DEL;
				"4": k = K_END;
				"5": k = K_PGUP;
				"6": k = K_PGDN;
				"7": k = K_HOME;
				"8": k = K_END;
				default: k = K_NONE;
			endcase
		end
		return k;
	endfunction

	// UTF-8 sequence length from the lead byte, zero for a bad lead
	function automatic logic [2:0] utf_len(input logic [7:0] b);
		logic [2:0] n;
		if (b < 8'h80) begin
			n = 3'd1;
		end else if (b >= 8'hc0 && b <= 8'hdf) begin
			n = 3'd2;
		end else if (b >= 8'he0 && b <= 8'hef) begin
			n = 3'd3;
		end else if (b >= 8'hf0 && b <= 8'hf7) begin
			n = 3'd4;
		end else begin
			n = 3'd0;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### design/tksd_in_stage.sv
// ---------------------------------------------------------------------------
// Terminal key sequence decoder input stage
// Registers one input word and stalls only when it cannot move on.
// ---------------------------------------------------------------------------
`default_nettype none

module tksd_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire tksd_pkg::item_t in_item,
	input  wire logic            blocked,
	output logic                 in_stall,
	output logic                 valid_s1,
	output tksd_pkg::item_t      item_s1
);
	import tksd_pkg::*;

	logic valid_s1_q;
	item_t item_s1_q;

	// Hold the word only while the result side is blocked
	assign in_stall = valid_s1_q && blocked;

	// Control: load a new word whenever the stage drains or is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (!in_stall) begin
			valid_s1_q <= in_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1_q <= in_item;
		end
	end

	assign valid_s1 = valid_s1_q;
	assign item_s1  = item_s1_q;

endmodule

`default_nettype wire

### design/tksd_decode.sv
// ---------------------------------------------------------------------------
// Terminal key sequence decoder parser
// Parse state, configuration registers and the per-word decode logic.
// ---------------------------------------------------------------------------
`default_nettype none

module tksd_decode #(
	parameter int TIMER_BITS = tksd_pkg::TIMER_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [tksd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tksd_pkg::TIMEOUT_W-1:0]    cfg_data,
	input  wire logic                              valid_s1,
	input  wire tksd_pkg::item_t                   item_s1,
	input  wire logic                              blocked,
	output logic                                   res_valid,
	output tksd_pkg::result_t                      res
);
	import tksd_pkg::*;

	localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
	localparam logic [TIMER_BITS-1:0] WAIT_FULL = {TIMER_BITS{1'b1}};

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ESC   = 3'd1,
		PH_INTRO = 3'd2,
		PH_DIGIT = 3'd3,
		PH_UTF   = 3'd4
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [7:0]             intro_q, intro_d;
	logic [7:0]             digit_q, digit_d;
	logic [TIMER_BITS-1:0]  wait_q, wait_d;
	logic [31:0]            gathered_q, gathered_d;
	logic [2:0]             expected_q, expected_d;
	logic [2:0]             count_q, count_d;
	logic [TIMEOUT_W-1:0]   timeout_q;
	logic                   del_bsp_q;

	logic                   advance;
	logic                   tick;
	logic [7:0]             b;
	logic [TIMER_BITS-1:0]  wait_inc;
	logic                   wait_done;
	logic [2:0]             count_inc;
	logic [31:0]            byte_shifted;
	logic [2:0]             lead_len;

	assign advance = valid_s1 && !blocked;
	assign tick    = item_s1.func;
	assign b       = item_s1.data_byte;

	// Saturating tick count and timeout compare
	assign wait_inc  = (wait_q != WAIT_FULL) ? TIMER_BITS'(wait_q + 1'b1) : wait_q;
	assign wait_done = (CMP_W'(wait_inc) >= CMP_W'(timeout_q)) || (wait_inc == WAIT_FULL);

	// Place the next UTF-8 byte at its lane
	assign count_inc    = count_q + 3'd1;
	assign byte_shifted = {24'd0, b} << {count_q[1:0], 3'b000};
	assign lead_len     = utf_len(b);

	// Next state and result for the word in stage one
	always_comb begin
		phase_d    = phase_q;
		intro_d    = intro_q;
		digit_d    = digit_q;
		wait_d     = wait_q;
		gathered_d = gathered_q;
		expected_d = expected_q;
		count_d    = count_q;
		res_valid  = 1'b0;
		res        = '0;
		case (phase_q)
			PH_ESC: begin
				if (tick) begin
					wait_d = wait_inc;
					if (wait_done) begin
						phase_d         = PH_IDLE;
						res_valid       = 1'b1;
						res.event_kind  = KIND_SPECIAL;
						res.special_key = K_ESC;
					end
				end else if (b == ESC_BYTE) begin
					wait_d = '0;
				end else if (b == CH_CSI || b == CH_SS3) begin
					phase_d = PH_INTRO;
					intro_d = b;
					wait_d  = '0;
				end else begin
					phase_d         = PH_IDLE;
					res_valid       = 1'b1;
					res.event_kind  = KIND_SPECIAL;
					res.special_key = K_ESC;
				end
			end
			PH_INTRO: begin
				if (!tick) begin
					if (is_digit(b)) begin
						phase_d = PH_DIGIT;
						digit_d = b;
					end else if (is_final(b)) begin
						phase_d         = PH_IDLE;
						res_valid       = 1'b1;
						res.event_kind  = KIND_SPECIAL;
						res.special_key = letter_key(intro_q, b);
					end else begin
						phase_d   = PH_IDLE;
						res_valid = 1'b1;
					end
				end
			end
			PH_DIGIT: begin
				if (!tick) begin
					phase_d         = PH_IDLE;
					res_valid       = 1'b1;
					res.event_kind  = KIND_SPECIAL;
					res.special_key = digit_key(intro_q, digit_q, b);
				end
			end
			PH_UTF: begin
				if (!tick) begin
					if (count_q < 3'd4) begin
						gathered_d = gathered_q | byte_shifted;
					end
					count_d = count_inc;
					if (count_inc >= expected_q || count_inc >= 3'd4) begin
						phase_d         = PH_IDLE;
						res_valid       = 1'b1;
						res.event_kind  = KIND_UTF;
						res.char_bytes  = (count_q < 3'd4) ? (gathered_q | byte_shifted)
							: gathered_q;
						res.char_length = count_inc;
					end
				end
			end
			default: begin
				// Idle, and any stray phase code behaves as idle
				phase_d = PH_IDLE;
				if (!tick) begin
					if (b == ESC_BYTE) begin
						phase_d = PH_ESC;
						wait_d  = '0;
					end else if (b == DEL_BYTE) begin
						res_valid       = 1'b1;
						res.event_kind  = KIND_SPECIAL;
						res.special_key = del_bsp_q ? K_BSP : K_DEL;
					end else if ((b & CTRL_MASK) == 8'd0) begin
						res_valid       = 1'b1;
						res.event_kind  = KIND_CTRL;
						res.ctrl_letter = b | CTRL_SET;
					end else if (lead_len == 3'd0) begin
						res_valid = 1'b1;
					end else if (lead_len == 3'd1) begin
						res_valid       = 1'b1;
						res.event_kind  = KIND_UTF;
						res.char_bytes  = {24'd0, b};
						res.char_length = 3'd1;
					end else begin
						phase_d    = PH_UTF;
						gathered_d = {24'd0, b};
						expected_d = lead_len;
						count_d    = 3'd1;
					end
				end
			end
		endcase
	end

	// Parse state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			intro_q    <= '0;
			digit_q    <= '0;
			wait_q     <= '0;
			gathered_q <= '0;
			expected_q <= '0;
			count_q    <= '0;
			timeout_q  <= TIMEOUT_RESET;
			del_bsp_q  <= 1'b1;
		end else begin
			if (advance) begin
				phase_q    <= phase_d;
				intro_q    <= intro_d;
				digit_q    <= digit_d;
				wait_q     <= wait_d;
				gathered_q <= gathered_d;
				expected_q <= expected_d;
				count_q    <= count_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_DEL_BSP: del_bsp_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### design/tksd_out_stage.sv
// ---------------------------------------------------------------------------
// Terminal key sequence decoder result register
// Holds one result word until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module tksd_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire logic              res_valid,
	input  wire tksd_pkg::result_t res,
	input  wire logic              out_stall,
	output logic                   blocked,
	output logic                   out_valid,
	output tksd_pkg::result_t      out_res
);
	import tksd_pkg::*;

	logic    out_valid_q;
	result_t res_q;
	logic    load;

	// Busy while a word waits and the consumer stalls
	assign blocked = out_valid_q && out_stall;
	assign load    = valid_s1 && res_valid && !blocked;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!blocked) begin
			out_valid_q <= load;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire

### design/terminal_key_sequence_decoder.sv
// ---------------------------------------------------------------------------
// Terminal key sequence decoder
// Turns terminal bytes and time ticks into key events.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | func, data_byte
//  out     | out_valid / out_stall| event_kind, special_key, ctrl_letter,
//          |                      | char_bytes, char_length
//  cfg     | cfg_we               | cfg_index, cfg_data
//
//  One word per cycle in while in_stall is low; a taken word is decoded from the
//  input register and its result is registered in the result register.
//  The parse state closes its loop through the decode logic.
//  in_stall rises only when both registers are full and out_stall is high.
//  Reset returns the parser to idle and loads timeout 250000, backspace mode.
// ---------------------------------------------------------------------------
`default_nettype none

module terminal_key_sequence_decoder #(
	parameter int TIMER_BITS = tksd_pkg::TIMER_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           func,
	input  wire logic [7:0]                     data_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          event_kind,
	output logic [3:0]                          special_key,
	output logic [7:0]                          ctrl_letter,
	output logic [31:0]                         char_bytes,
	output logic [2:0]                          char_length,
	input  wire logic                           cfg_we,
	input  wire logic [tksd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tksd_pkg::TIMEOUT_W-1:0] cfg_data
);
	import tksd_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    blocked;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign in_item.func      = func;
	assign in_item.data_byte = data_byte;

	tksd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.blocked  (blocked),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tksd_decode #(
		.TIMER_BITS (TIMER_BITS)
	) u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.blocked   (blocked),
		.res_valid (res_valid),
		.res       (res)
	);

	tksd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.blocked   (blocked),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign event_kind  = out_res.event_kind;
	assign special_key = out_res.special_key;
	assign ctrl_letter = out_res.ctrl_letter;
	assign char_bytes  = out_res.char_bytes;
	assign char_length = out_res.char_length;

endmodule

`default_nettype wire

### design/tksd_checker.sv
// ---------------------------------------------------------------------------
// Terminal key sequence decoder port checker
// Checks result words and the output handshake seen at the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none

`include "terminal_key_sequence_decoder_assert.svh"

module tksd_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  event_kind,
	input wire logic [3:0]  special_key,
	input wire logic [7:0]  ctrl_letter,
	input wire logic [31:0] char_bytes,
	input wire logic [2:0]  char_length
);
	import tksd_pkg::*;

	// A stalled result word stays and holds its payload
	`TKSD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(event_kind) && $stable(special_key) && $stable(ctrl_letter)
		&& $stable(char_bytes) && $stable(char_length), "result word changed under stall")

	// Input stalls only behind a stalled result word
	`TKSD_ASSERT_NOW(a_in_stall_cause, clk, arst_n, in_stall, out_valid && out_stall,
		"input stalled without a stalled result")

	// Only special events carry a key code
	`TKSD_ASSERT_NOW(a_key_only_special, clk, arst_n,
		out_valid && event_kind != KIND_SPECIAL, special_key == K_NONE,
		"key code on a non-special event")

	// Control letters always have bit 6 set and bit 5 clear
	`TKSD_ASSERT_NOW(a_ctrl_form, clk, arst_n, out_valid && event_kind == KIND_CTRL,
		ctrl_letter[6] && !ctrl_letter[5], "malformed control letter")

	// Character words carry one to four bytes, others none
	`TKSD_ASSERT_NOW(a_char_len, clk, arst_n, out_valid,
		(event_kind == KIND_UTF) ? (char_length != 3'd0 && char_length <= 3'd4)
		: (char_length == 3'd0 && char_bytes == 32'd0), "bad character length")

endmodule

bind terminal_key_sequence_decoder tksd_port_checker u_port_checker (.*);

`default_nettype wire

### bench/tksd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terminal key sequence decoder checker
// Watches the input, output and register ports of the decoder, predicts the
// key event of every accepted word and compares each accepted result word
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tksd_checker #(
	parameter int TIMER_BITS = tksd_pkg::TIMER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           func,
	input  logic [7:0]                     data_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [1:0]                     event_kind,
	input  logic [3:0]                     special_key,
	input  logic [7:0]                     ctrl_letter,
	input  logic [31:0]                    char_bytes,
	input  logic [2:0]                     char_length,
	input  logic                           cfg_we,
	input  logic [tksd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tksd_pkg::TIMEOUT_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             events_due
);
	import tksd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC_WAIT,
		PH_INTRO,
		PH_DIGIT,
		PH_UTF
	} phase_t;

	localparam logic [TIMER_BITS-1:0] COUNT_FULL = '1;

	// Predicted parser state and register copies
	phase_t                phase;
	logic [7:0]            intro;
	logic [7:0]            digit;
	logic [TIMER_BITS-1:0] wait_cnt;
	logic [31:0]           gathered;
	logic [2:0]            need;
	logic [2:0]            got;
	logic [TIMEOUT_W-1:0]  timeout;
	logic                  del_bsp;

	result_t expected_events[$];
	int      bad_count;

	function automatic result_t key_event(input logic [1:0] kind, input logic [3:0] key,
			input logic [7:0] ctl, input logic [31:0] bytes, input logic [2:0] len);
		result_t r;
		r.event_kind  = kind;
		r.special_key = key;
		r.ctrl_letter = ctl;
		r.char_bytes  = bytes;
		r.char_length = len;
		return r;
	endfunction

	function automatic logic is_final_letter(input logic [7:0] b);
		case (b)
			"A", "B", "C", "D", "H", "F", "P", "V", "U", "Y": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Letter after the introducer; P V U Y only mean something after '['
	function automatic logic [3:0] letter_key_of(input logic [7:0] intro_ch,
			input logic [7:0] b);
		logic [3:0] k;
		logic       csi;
		csi = (intro_ch == CH_CSI);
		case (b)
			"A": k = K_UP;
			"B": k = K_DOWN;
			"C": k = K_RIGHT;
			"D": k = K_LEFT;
			"H": k = K_HOME;
			"F": k = K_END;
			"P": k = csi ? K_DEL : K_NONE;
			"V": k = csi ? K_PGUP : K_NONE;
			"U": k = csi ? K_PGDN : K_NONE;
			"Y": k = csi ? K_END : K_NONE;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	// Digit form: ESC [ n ~ and ESC [ 4 h
	function automatic logic [3:0] tilde_key_of(input logic [7:0] intro_ch,
			input logic [7:0] d, input logic [7:0] b);
		logic [3:0] k;
		k = K_NONE;
		if (intro_ch == CH_CSI && b == "~") begin
			case (d)
				"1", "7": k = K_HOME;
				"3":      k = K_DEL;
				"4", "8": k = K_END;
				"5":      k = K_PGUP;
				"6":      k = K_PGDN;
				default:  k = K_NONE;
			endcase
		end else if (intro_ch == CH_CSI && b == "h" && d == "4") begin
			k = K_INS;
		end
		return k;
	endfunction

	// UTF-8 length from the lead byte's top bits, zero when it cannot lead
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		if (!b[7])
			return 3'd1;
		if (b[7:5] == 3'b110)
			return 3'd2;
		if (b[7:4] == 4'b1110)
			return 3'd3;
		if (b[7:3] == 5'b11110)
			return 3'd4;
		return 3'd0;
	endfunction

	task automatic back_to_idle();
		phase    = PH_IDLE;
		intro    = '0;
		digit    = '0;
		wait_cnt = '0;
		gathered = '0;
		need     = '0;
		got      = '0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got_val,
			input logic [31:0] want_val);
		if (bad_count < 50)
			$display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what,
				got_val, want_val);
		bad_count++;
	endtask

	// Advance the predicted parser by one accepted word
	task automatic decode_word(input logic tick, input logic [7:0] b);
		logic [2:0] n;
		case (phase)
			PH_ESC_WAIT: begin
				if (tick) begin
					if (wait_cnt != COUNT_FULL)
						wait_cnt = wait_cnt + 1'b1;
					if (wait_cnt >= timeout || wait_cnt == COUNT_FULL) begin
						back_to_idle();
						expected_events.push_back(key_event(KIND_SPECIAL, K_ESC, '0, '0, '0));
					end
				end else if (b == ESC_BYTE) begin
					wait_cnt = '0;
				end else if (b == CH_CSI || b == CH_SS3) begin
					phase    = PH_INTRO;
					intro    = b;
					wait_cnt = '0;
				end else begin
					// any other byte ends the wait and is dropped
					back_to_idle();
					expected_events.push_back(key_event(KIND_SPECIAL, K_ESC, '0, '0, '0));
				end
			end
			PH_INTRO: begin
				if (!tick) begin
					if (b >= "0" && b <= "9") begin
						phase = PH_DIGIT;
						digit = b;
					end else if (is_final_letter(b)) begin
						expected_events.push_back(key_event(KIND_SPECIAL,
							letter_key_of(intro, b), '0, '0, '0));
						back_to_idle();
					end else begin
						back_to_idle();
						expected_events.push_back(key_event(KIND_NONE, K_NONE, '0, '0, '0));
					end
				end
			end
			PH_DIGIT: begin
				if (!tick) begin
					expected_events.push_back(key_event(KIND_SPECIAL,
						tilde_key_of(intro, digit, b), '0, '0, '0));
					back_to_idle();
				end
			end
			PH_UTF: begin
				if (!tick) begin
					if (got < 3'd4)
						gathered = gathered | ({24'h0, b} << {got, 3'b000});
					got = got + 1'b1;
					if (got >= need || got >= 3'd4) begin
						expected_events.push_back(key_event(KIND_UTF, K_NONE, '0, gathered, got));
						back_to_idle();
					end
				end
			end
			default: begin
				if (!tick) begin
					n = lead_length(b);
					if (b == ESC_BYTE) begin
						phase    = PH_ESC_WAIT;
						wait_cnt = '0;
					end else if (b == DEL_BYTE) begin
						expected_events.push_back(key_event(KIND_SPECIAL,
							del_bsp ? K_BSP : K_DEL, '0, '0, '0));
					end else if ((b & CTRL_MASK) == 8'h00) begin
						expected_events.push_back(key_event(KIND_CTRL, K_NONE, b | CTRL_SET,
							'0, '0));
					end else if (n == 3'd0) begin
						expected_events.push_back(key_event(KIND_NONE, K_NONE, '0, '0, '0));
					end else if (n == 3'd1) begin
						expected_events.push_back(key_event(KIND_UTF, K_NONE, '0, {24'h0, b},
							3'd1));
					end else begin
						phase    = PH_UTF;
						gathered = {24'h0, b};
						need     = n;
						got      = 3'd1;
					end
				end
			end
		endcase
	endtask

	// Compare one accepted result word with the oldest prediction
	task automatic check_result();
		result_t want;
		if (expected_events.size() == 0) begin
			report_mismatch("unexpected word, event_kind", {30'h0, event_kind}, '0);
		end else begin
			want = expected_events.pop_front();
			if (event_kind !== want.event_kind)
				report_mismatch("event_kind", {30'h0, event_kind}, {30'h0, want.event_kind});
			if (special_key !== want.special_key)
				report_mismatch("special_key", {28'h0, special_key}, {28'h0, want.special_key});
			if (ctrl_letter !== want.ctrl_letter)
				report_mismatch("ctrl_letter", {24'h0, ctrl_letter}, {24'h0, want.ctrl_letter});
			if (char_bytes !== want.char_bytes)
				report_mismatch("char_bytes", char_bytes, want.char_bytes);
			if (char_length !== want.char_length)
				report_mismatch("char_length", {29'h0, char_length}, {29'h0, want.char_length});
		end
	endtask

	// Track registers, check results, then predict the accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout   = TIMEOUT_RESET;
			del_bsp   = 1'b1;
			back_to_idle();
			expected_events.delete();
			bad_count = 0;
			mismatches <= 0;
			events_due <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TIMEOUT)
					timeout = cfg_data;
				else if (cfg_index == REG_DEL_BSP)
					del_bsp = cfg_data[0];
			end
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				decode_word(func, data_byte);
			mismatches <= bad_count;
			events_due <= expected_events.size();
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terminal key sequence decoder testbench
// Resets the decoder, runs a directed set of bytes, key sequences, timeouts
// and UTF-8 characters, then phases of random sequences under several
// register settings with random gaps and stalls on both sides. The checker
// beside the block does all prediction and comparison.
// ---------------------------------------------------------------------------
module tb;
	import tksd_pkg::*;

	localparam int RANDOM_WORDS  = 1400;
	localparam int PHASE_WORDS   = 175;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 80;
	localparam logic [TIMEOUT_W-1:0] LONG_TIMEOUT = 18'd200;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 func;
	logic [7:0]           data_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           event_kind;
	logic [3:0]           special_key;
	logic [7:0]           ctrl_letter;
	logic [31:0]          char_bytes;
	logic [2:0]           char_length;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIMEOUT_W-1:0] cfg_data;

	int                   mismatches;
	int                   events_due;
	int                   words_sent;
	int                   stall_left;
	int                   phase_no;
	int                   phase_end;
	logic                 calm;
	logic                 hold_req;
	logic [TIMEOUT_W-1:0] phase_ticks;

	terminal_key_sequence_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_kind(event_kind), .special_key(special_key), .ctrl_letter(ctrl_letter),
		.char_bytes(char_bytes), .char_length(char_length),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tksd_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_kind(event_kind), .special_key(special_key), .ctrl_letter(ctrl_letter),
		.char_bytes(char_bytes), .char_length(char_length),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .events_due(events_due)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog
	initial begin
		#(64'd40_000_000);
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver: random stalls, one long hold-off on request
	initial begin
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (calm || $urandom_range(0, 99) < 65) begin
				out_stall <= 1'b0;
			end else begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
					: $urandom_range(0, 2);
				out_stall <= 1'b1;
			end
		end
	end

	// Mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_final();
		case ($urandom_range(0, 9))
			0: return "A";
			1: return "B";
			2: return "C";
			3: return "D";
			4: return "H";
			5: return "F";
			6: return "P";
			7: return "V";
			8: return "U";
			default: return "Y";
		endcase
	endfunction

	// Offer one word and hold it until taken; valid stays high into the next word
	task automatic send_word(input logic f, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid  <= 1'b0;
			func      <= 1'($urandom_range(0, 1));
			data_byte <= 8'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(1'b0, b);
		words_sent++;
	endtask

	task automatic send_tick();
		send_word(1'b1, 8'($urandom_range(0, 255)));
		words_sent++;
	endtask

	// Drain the block, then write both registers
	task automatic set_mode(input logic [TIMEOUT_W-1:0] ticks, input logic bsp);
		logic [TIMEOUT_W-1:0] noise;
		noise = TIMEOUT_W'($urandom);
		in_valid <= 1'b0;
		@(posedge clk);
		while (events_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= ticks;
		@(posedge clk);
		cfg_index <= REG_DEL_BSP;
		cfg_data  <= {noise[TIMEOUT_W-1:1], bsp};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// ESC, introducer, then a final letter, a digit form or a broken ending
	task automatic send_key_sequence();
		int pick;
		send_byte(ESC_BYTE);
		if ($urandom_range(0, 9) == 0)
			send_byte(ESC_BYTE);
		send_byte(($urandom_range(0, 3) == 0) ? CH_SS3 : CH_CSI);
		if ($urandom_range(0, 9) == 0)
			send_tick();
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			send_byte(pick_final());
		end else if (pick < 8) begin
			send_byte(8'(($urandom_range(0, 2) == 0) ? "4" : "0" + $urandom_range(0, 9)));
			if ($urandom_range(0, 9) == 0)
				send_tick();
			case ($urandom_range(0, 4))
				0, 1: send_byte("~");
				2: send_byte("h");
				default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Lone ESC followed by ticks around the timeout, with the odd repeated ESC
	task automatic send_lone_escape();
		int n;
		n = (phase_ticks > 60) ? 60 : int'(phase_ticks) + 2;
		n = $urandom_range(0, n);
		send_byte(ESC_BYTE);
		repeat (n) begin
			if ($urandom_range(0, 15) == 0)
				send_byte(ESC_BYTE);
			else
				send_tick();
		end
	endtask

	// Multi-byte UTF-8 character with random continuation bytes
	task automatic send_utf_char();
		int         len;
		logic [7:0] lead;
		len = $urandom_range(2, 4);
		case (len)
			2: lead = 8'hc0 | 8'($urandom_range(0, 31));
			3: lead = 8'he0 | 8'($urandom_range(0, 15));
			default: lead = 8'hf0 | 8'($urandom_range(0, 7));
		endcase
		send_byte(lead);
		repeat (len - 1) begin
			if ($urandom_range(0, 9) == 0)
				send_tick();
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_random_sequence();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_key_sequence();
		end else if (pick < 45) begin
			send_lone_escape();
		end else if (pick < 55) begin
			send_byte(ESC_BYTE);
			send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 75) begin
			send_utf_char();
		end else if (pick < 95) begin
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			// stray ticks, mostly ignored
			repeat ($urandom_range(1, 3)) send_word(1'b1, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		func       = 1'b0;
		data_byte  = 8'h00;
		cfg_we     = 1'b0;
		cfg_index  = REG_TIMEOUT;
		cfg_data   = '0;
		calm       = 1'b0;
		hold_req   = 1'b0;
		words_sent = 0;
		phase_ticks = TIMEOUT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single bytes at reset settings: control, high control, bad lead, DEL
		send_byte(8'h00);
		send_byte(8'h9f);
		send_byte(8'ha0);
		send_byte(8'hff);
		send_byte(DEL_BYTE);
		send_word(1'b1, 8'h5a);
		// Table hits, unmatched sequences and a bad final byte
		send_byte(ESC_BYTE); send_byte(CH_CSI); send_byte("A");
		send_byte(ESC_BYTE); send_byte(CH_SS3); send_byte("P");
		send_byte(ESC_BYTE); send_byte(CH_CSI); send_byte("4"); send_byte("h");
		send_byte(ESC_BYTE); send_byte(CH_CSI); send_byte("2"); send_byte("~");
		send_byte(ESC_BYTE); send_byte(CH_CSI); send_byte("x");
		// Repeated ESC, then a byte that is dropped
		send_byte(ESC_BYTE); send_byte(ESC_BYTE); send_byte("q");
		// Two- and four-byte characters
		send_byte(8'hc3); send_byte(8'ha9);
		send_byte(8'hf0); send_byte(8'h9f); send_byte(8'h98); send_byte(8'h80);

		// Shortest timeout and delete mode
		set_mode(18'd1, 1'b0);
		send_byte(ESC_BYTE); send_tick();
		send_byte(DEL_BYTE);
		// Zero timeout behaves as one tick
		set_mode('0, 1'b1);
		send_byte(ESC_BYTE); send_tick();

		// Long timeout: ESC waits out every tick up to the limit
		set_mode(LONG_TIMEOUT, 1'b1);
		calm = 1'b1;
		send_byte(ESC_BYTE);
		repeat (int'(LONG_TIMEOUT)) send_word(1'b1, 8'($urandom_range(0, 255)));
		calm = 1'b0;

		// Random phases, each under its own register setting
		words_sent = 0;
		for (phase_no = 0; words_sent < RANDOM_WORDS; phase_no++) begin
			if (phase_no == 0)
				phase_ticks = 18'd1;
			else if ($urandom_range(0, 4) == 0)
				phase_ticks = TIMEOUT_W'($urandom_range(30, 60));
			else
				phase_ticks = TIMEOUT_W'($urandom_range(1, 12));
			set_mode(phase_ticks, 1'($urandom_range(0, 1)));
			calm = (phase_no % 4 == 3);
			if (phase_no == 2) begin
				// hold the receiver off while control bytes keep coming
				hold_req = 1'b1;
				repeat (24) send_byte(8'($urandom_range(0, 31)));
			end
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end)
				send_random_sequence();
		end
		calm = 1'b0;

		// Drain and give the verdict
		in_valid <= 1'b0;
		@(posedge clk);
		while (events_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && events_due == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
